>>> src/sts_pkg.sv
// Shared types, codes and fixed-point widths for the swing step sequencer.
// Used by every module of the block; depends on nothing else.
package sts_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF    = 8;
    localparam int STEPS_MAX_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Results kept per item; later ones are dropped.
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 7;

    // Field and register widths.
    localparam int OP_W    = 3;
    localparam int NS_W    = 13;
    localparam int STEP_W  = 6;
    localparam int CHAN_W  = 3;
    localparam int TOFF_W  = 16;
    localparam int SOFF_W  = 12;
    localparam int SPS_W   = 38;
    localparam int SWING_W = 16;
    localparam int STEPS_W = 7;
    localparam int CFGI_W  = 2;

    // Internal arithmetic widths.
    localparam int ACC_W  = 39;  // unsigned Q23.16 accumulator, one step length plus one block
    localparam int TF_W   = 41;  // signed Q25.16 distance to the next step
    localparam int POS_W  = 25;  // signed sample position of a fired step
    localparam int WAIT_W = 24;  // samples left for a queued trigger
    localparam int PROD_W = 54;  // 16 x 38 bit product

    localparam logic [SPS_W-1:0]   SPS_MIN     = 38'd65536;
    localparam logic [SPS_W-1:0]   SPS_RESET   = 38'd393216000;
    localparam logic [SWING_W-1:0] SWING_MIN   = 16'd65;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd16;
    localparam logic signed [TOFF_W-1:0] TOFF_CLAMP   = 16'sd16384;
    localparam logic signed [TOFF_W-1:0] TOFF_MIN_MAG = 16'sd32;

    // Input operation codes.
    localparam logic [OP_W-1:0] OP_PROCESS = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_PATTERN = 3'd3;
    localparam logic [OP_W-1:0] OP_OFFSET  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFGI_W-1:0] CFG_SPS   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SWING = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_STEPS = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_PROCESS = 3'd1,
        CMD_START   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_PATTERN = 3'd4,
        CMD_OFFSET  = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic [NS_W-1:0]           ns;
        logic [STEP_W-1:0]         step;
        logic [CHAN_W-1:0]         chan;
        logic                      act;
        logic signed [TOFF_W-1:0]  toff;
    } t_item;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [STEP_W-1:0] step;
        logic [SOFF_W-1:0] offset;
        logic              last;
    } t_res;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [STEP_W-1:0] step;
        logic [WAIT_W-1:0] wait_cnt;
    } t_pend;

    typedef struct packed {
        logic              en;
        logic [CFGI_W-1:0] idx;
        logic [SPS_W-1:0]  data;
    } t_cfg_wr;

endpackage

>>> src/sts_front.sv
// Front end: accepts input items into a two-entry queue and classifies the op.
// Depends on sts_pkg.
module sts_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sts_pkg::OP_W-1:0]          i_op,
    input  logic [sts_pkg::NS_W-1:0]          i_num_samples,
    input  logic [sts_pkg::STEP_W-1:0]        i_step_index,
    input  logic [sts_pkg::CHAN_W-1:0]        i_channel_index,
    input  logic                              i_step_active,
    input  logic signed [sts_pkg::TOFF_W-1:0] i_timing_offset,
    output sts_pkg::t_item                    o_item,
    output logic                              o_valid,
    input  logic                              i_take
);

    sts_pkg::t_item r_slot [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    sts_pkg::t_item cls;
    logic           wr, rd;

    always_comb begin
        cls.ns   = i_num_samples;
        cls.step = i_step_index;
        cls.chan = i_channel_index;
        cls.act  = i_step_active;
        cls.toff = i_timing_offset;
        unique case (i_op)
            sts_pkg::OP_PROCESS: begin
                // An empty block does nothing at all.
                cls.cmd = (i_num_samples == '0) ? sts_pkg::CMD_NOP : sts_pkg::CMD_PROCESS;
            end
            sts_pkg::OP_START:   cls.cmd = sts_pkg::CMD_START;
            sts_pkg::OP_STOP:    cls.cmd = sts_pkg::CMD_STOP;
            sts_pkg::OP_PATTERN: cls.cmd = sts_pkg::CMD_PATTERN;
            sts_pkg::OP_OFFSET:  cls.cmd = sts_pkg::CMD_OFFSET;
            default:             cls.cmd = sts_pkg::CMD_NOP;
        endcase
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign wr      = push && !full;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

>>> src/sts_out_fifo.sv
// Result queue between the sequencer core and the result ports.
// Depends on sts_pkg.
module sts_out_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sts_pkg::t_res i_res,
    output logic          o_full,
    output logic          empty,
    input  logic          pop,
    output sts_pkg::t_res o_res
);

    sts_pkg::t_res r_mem [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic          wr, rd;

    assign o_full = (r_cnt == 3'd4);
    assign empty  = (r_cnt == 3'd0);
    assign o_res  = r_mem[r_rp];
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + 2'(wr);
            r_rp  <= r_rp + 2'(rd);
            r_cnt <= r_cnt + 3'(wr) - 3'(rd);
        end
    end

endmodule

>>> src/sts_core.sv
// Back end: sequencer state, pattern and offset stores, trigger queue and
// the step engine with its shared multiplier. Depends on sts_pkg.
module sts_core #(
    parameter int CHANNELS    = sts_pkg::CHANNELS_DEF,
    parameter int STEPS_MAX   = sts_pkg::STEPS_MAX_DEF,
    parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sts_pkg::t_cfg_wr i_cfg,
    input  sts_pkg::t_item   i_item,
    input  logic             i_item_valid,
    output logic             o_item_take,
    output sts_pkg::t_res    o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);

    localparam int ST_W = (STEPS_MAX > 1) ? $clog2(STEPS_MAX) : 1;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = sts_pkg::SPS_W;
    localparam int PW   = sts_pkg::PROD_W;
    localparam int TW   = sts_pkg::TF_W;
    localparam int PSW  = sts_pkg::POS_W;
    localparam int WW   = sts_pkg::WAIT_W;
    localparam int NW   = sts_pkg::NS_W;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DRN_RD = 15'b000000000000010,
        S_DRN_EV = 15'b000000000000100,
        S_INIT   = 15'b000000000001000,
        S_STEP   = 15'b000000000010000,
        S_F_RD   = 15'b000000000100000,
        S_SW0    = 15'b000000001000000,
        S_SW1    = 15'b000000010000000,
        S_SW2    = 15'b000000100000000,
        S_OF0    = 15'b000001000000000,
        S_OF1    = 15'b000010000000000,
        S_OF2    = 15'b000100000000000,
        S_CLAMP  = 15'b001000000000000,
        S_CHAN   = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0]                      r_sps, n_sps;
    logic [sts_pkg::SWING_W-1:0]        r_swing, n_swing;
    logic [sts_pkg::STEPS_W-1:0]        r_steps, n_steps;
    logic                               r_running, n_running;
    logic [sts_pkg::STEP_W-1:0]         r_pos_step, n_pos_step;
    logic [sts_pkg::ACC_W-1:0]          r_acc, n_acc;
    logic                               r_fire_first, n_fire_first;
    logic [QC_W-1:0]                    r_pcount, n_pcount;
    logic [QC_W-1:0]                    r_di, n_di, r_dw, n_dw;
    sts_pkg::t_item                     r_item, n_item;
    logic signed [TW-1:0]               r_tf, n_tf;
    logic signed [PSW-1:0]              r_fpos, n_fpos;
    logic [PW-1:0]                      r_prod, n_prod;
    logic signed [sts_pkg::TOFF_W-1:0]  r_so, n_so;
    logic [CH_W-1:0]                    r_ch, n_ch;
    sts_pkg::t_res                      r_hold, n_hold;
    logic                               r_hold_vld, n_hold_vld;
    logic [sts_pkg::RES_CNT_W-1:0]      r_res_n, n_res_n;

    logic [STEPS_MAX-1:0]               r_pattern [CHANNELS];
    logic [STEPS_MAX-1:0]               r_off_vld;
    logic signed [sts_pkg::TOFF_W-1:0]  off_mem [STEPS_MAX];
    logic signed [sts_pkg::TOFF_W-1:0]  r_off_q;
    logic                               r_off_vld_q;
    sts_pkg::t_pend                     pq_mem [QUEUE_DEPTH];
    sts_pkg::t_pend                     r_pq_q;

    // Store controls.
    logic                               pat_we, off_we, pq_we;
    logic [ST_W-1:0]                    off_raddr;
    logic [QI_W-1:0]                    pq_raddr, pq_waddr;
    sts_pkg::t_pend                     pq_wdata;
    logic signed [sts_pkg::TOFF_W-1:0]  toff_clamped;

    // Result path.
    logic                               emit_req, emit_stall, emit_go, res_room;
    sts_pkg::t_res                      emit_data;
    logic                               push_done;

    // Arithmetic.
    logic [sts_pkg::SWING_W-1:0]        mul_a, so_mag;
    logic [47:0]                        mul_lo;
    logic [21:0]                        mul_hi;
    logic [PW:0]                        rnd_sw_sum, rnd_of_sum;
    logic signed [TW-1:0]               tf_rnd;
    logic [PSW-1:0]                     base_raw;
    logic [PSW-1:0]                     ns_m1;
    logic signed [PSW-1:0]              ns_pos;
    logic [sts_pkg::STEPS_W-1:0]        steps_cfg, start_step, next_step;
    logic                               pat_hit, last_ch;
    logic [SW-1:0]                      sps_cfg;

    assign ns_pos     = $signed({{(PSW-NW){1'b0}}, r_item.ns});
    assign ns_m1      = {{(PSW-NW){1'b0}}, r_item.ns} - PSW'(1);
    assign res_room   = (r_res_n < sts_pkg::RES_CNT_W'(sts_pkg::MAX_RESULTS));
    assign emit_stall = emit_req && res_room && r_hold_vld && i_res_full;
    assign emit_go    = emit_req && !emit_stall;
    assign so_mag     = r_so[sts_pkg::TOFF_W-1] ? sts_pkg::SWING_W'(-r_so)
                                                : sts_pkg::SWING_W'(r_so);
    assign mul_lo     = 48'(mul_a) * 48'(r_sps[31:0]);
    assign mul_hi     = 22'(mul_a) * 22'(r_sps[SW-1:32]);
    assign rnd_sw_sum = {1'b0, r_prod} + ((PW+1)'(1) << 31);
    assign rnd_of_sum = {1'b0, r_prod} + ((PW+1)'(1) << 30);
    assign tf_rnd     = r_tf + TW'(32768);
    assign base_raw   = PSW'(tf_rnd[TW-1:16]);
    assign pat_hit    = r_pattern[r_ch][r_pos_step[ST_W-1:0]];
    assign last_ch    = (r_ch == CH_W'(CHANNELS - 1));
    assign next_step  = sts_pkg::STEPS_W'(r_pos_step) + 7'd1;
    assign start_step = ({1'b0, i_item.step} > r_steps - 7'd1) ? r_steps - 7'd1
                                                              : {1'b0, i_item.step};

    always_comb begin
        if (i_item.toff > sts_pkg::TOFF_CLAMP) begin
            toff_clamped = sts_pkg::TOFF_CLAMP;
        end else if (i_item.toff < -sts_pkg::TOFF_CLAMP) begin
            toff_clamped = -sts_pkg::TOFF_CLAMP;
        end else begin
            toff_clamped = i_item.toff;
        end
        steps_cfg = i_cfg.data[sts_pkg::STEPS_W-1:0];
        if (steps_cfg < 7'd1) begin
            steps_cfg = 7'd1;
        end else if (32'(steps_cfg) > STEPS_MAX) begin
            steps_cfg = sts_pkg::STEPS_W'(STEPS_MAX);
        end
        sps_cfg = (i_cfg.data < sts_pkg::SPS_MIN) ? sts_pkg::SPS_MIN : i_cfg.data;
    end

    always_comb begin
        n_state      = r_state;
        n_sps        = r_sps;
        n_swing      = r_swing;
        n_steps      = r_steps;
        n_running    = r_running;
        n_pos_step   = r_pos_step;
        n_acc        = r_acc;
        n_fire_first = r_fire_first;
        n_pcount     = r_pcount;
        n_di         = r_di;
        n_dw         = r_dw;
        n_item       = r_item;
        n_tf         = r_tf;
        n_fpos       = r_fpos;
        n_prod       = r_prod;
        n_so         = r_so;
        n_ch         = r_ch;
        n_hold       = r_hold;
        n_hold_vld   = r_hold_vld;
        n_res_n      = r_res_n;
        o_item_take  = 1'b0;
        pat_we       = 1'b0;
        off_we       = 1'b0;
        pq_we        = 1'b0;
        pq_waddr     = r_dw[QI_W-1:0];
        pq_wdata     = r_pq_q;
        pq_raddr     = r_di[QI_W-1:0];
        off_raddr    = r_pos_step[ST_W-1:0];
        emit_req     = 1'b0;
        emit_data    = '0;
        mul_a        = r_swing;
        push_done    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_item_take = i_item_valid;
                if (i_item_valid) begin
                    n_item = i_item;
                    case (i_item.cmd)
                        sts_pkg::CMD_PROCESS: begin
                            if (r_running) begin
                                n_di    = '0;
                                n_dw    = '0;
                                n_state = S_DRN_RD;
                            end
                        end
                        sts_pkg::CMD_START: begin
                            n_pos_step   = start_step[sts_pkg::STEP_W-1:0];
                            n_acc        = '0;
                            n_running    = 1'b1;
                            n_fire_first = 1'b1;
                            n_pcount     = '0;
                        end
                        sts_pkg::CMD_STOP: begin
                            n_running = 1'b0;
                            n_pcount  = '0;
                        end
                        sts_pkg::CMD_PATTERN: begin
                            pat_we = (32'(i_item.chan) < CHANNELS)
                                  && ({1'b0, i_item.step} < r_steps)
                                  && (32'(i_item.step) < STEPS_MAX);
                        end
                        sts_pkg::CMD_OFFSET: begin
                            off_we = (32'(i_item.step) < STEPS_MAX);
                        end
                        default: ;
                    endcase
                end
            end
            S_DRN_RD: begin
                if (r_di == r_pcount) begin
                    n_pcount = r_dw;
                    n_state  = S_INIT;
                end else begin
                    n_state = S_DRN_EV;
                end
            end
            S_DRN_EV: begin
                if (r_pq_q.wait_cnt < WW'(r_item.ns)) begin
                    emit_req  = 1'b1;
                    emit_data = '{chan: r_pq_q.chan, step: r_pq_q.step,
                                  offset: r_pq_q.wait_cnt[sts_pkg::SOFF_W-1:0], last: 1'b0};
                    if (emit_go) begin
                        n_di    = r_di + QC_W'(1);
                        n_state = S_DRN_RD;
                    end
                end else begin
                    pq_we             = 1'b1;
                    pq_wdata.wait_cnt = r_pq_q.wait_cnt - WW'(r_item.ns);
                    n_dw              = r_dw + QC_W'(1);
                    n_di              = r_di + QC_W'(1);
                    n_state           = S_DRN_RD;
                end
            end
            S_INIT: begin
                n_tf  = $signed(TW'(r_sps)) - $signed(TW'(r_acc));
                n_acc = r_acc + sts_pkg::ACC_W'({r_item.ns, 16'd0});
                if (r_fire_first) begin
                    n_fire_first = 1'b0;
                    n_fpos       = '0;
                    n_state      = S_F_RD;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_acc >= sts_pkg::ACC_W'(r_sps)) begin
                    n_acc = r_acc - sts_pkg::ACC_W'(r_sps);
                    // A step that fell before this block starts at offset zero.
                    if (r_tf < 0) begin
                        n_fpos = '0;
                    end else if (base_raw > ns_m1) begin
                        n_fpos = $signed(ns_m1);
                    end else begin
                        n_fpos = $signed(base_raw);
                    end
                    n_pos_step = (next_step == r_steps) ? '0
                                                        : next_step[sts_pkg::STEP_W-1:0];
                    n_tf    = r_tf + $signed(TW'(r_sps));
                    n_state = S_F_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_RD: begin
                n_state = S_SW0;
            end
            S_SW0: begin
                n_so    = r_off_vld_q ? r_off_q : '0;
                n_prod  = PW'(mul_lo);
                n_state = S_SW1;
            end
            S_SW1: begin
                n_prod  = r_prod + {mul_hi, 32'd0};
                n_state = S_SW2;
            end
            S_SW2: begin
                if ((r_swing > sts_pkg::SWING_MIN) && r_pos_step[0]) begin
                    n_fpos = r_fpos + $signed(PSW'(rnd_sw_sum[PW:32]));
                end
                n_state = S_OF0;
            end
            S_OF0: begin
                mul_a   = so_mag;
                n_prod  = PW'(mul_lo);
                n_state = S_OF1;
            end
            S_OF1: begin
                mul_a   = so_mag;
                n_prod  = r_prod + {mul_hi, 32'd0};
                n_state = S_OF2;
            end
            S_OF2: begin
                if (r_so > sts_pkg::TOFF_MIN_MAG) begin
                    n_fpos = r_fpos + $signed(PSW'(rnd_of_sum[PW:31]));
                end else if (r_so < -sts_pkg::TOFF_MIN_MAG) begin
                    n_fpos = r_fpos - $signed(PSW'(rnd_of_sum[PW:31]));
                end
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_fpos < 0) begin
                    n_fpos = '0;
                end
                n_ch    = '0;
                n_state = S_CHAN;
            end
            S_CHAN: begin
                logic adv;
                adv = 1'b1;
                if (pat_hit) begin
                    if (r_fpos < ns_pos) begin
                        emit_req  = 1'b1;
                        emit_data = '{chan: sts_pkg::CHAN_W'(r_ch), step: r_pos_step,
                                      offset: r_fpos[sts_pkg::SOFF_W-1:0], last: 1'b0};
                        adv       = emit_go;
                    end else if (r_pcount < QC_W'(QUEUE_DEPTH)) begin
                        pq_we    = 1'b1;
                        pq_waddr = r_pcount[QI_W-1:0];
                        pq_wdata = '{chan: sts_pkg::CHAN_W'(r_ch), step: r_pos_step,
                                     wait_cnt: WW'(r_fpos - ns_pos)};
                        n_pcount = r_pcount + QC_W'(1);
                    end
                end
                if (adv) begin
                    if (last_ch) begin
                        n_state = S_STEP;
                    end else begin
                        n_ch = r_ch + CH_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_hold_vld) begin
                    n_res_n = '0;
                    n_state = S_IDLE;
                end else if (!i_res_full) begin
                    push_done  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_res_n    = '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A new result pushes out the one held before it.
        if (emit_go && res_room) begin
            n_hold     = emit_data;
            n_hold_vld = 1'b1;
            n_res_n    = r_res_n + sts_pkg::RES_CNT_W'(1);
        end

        if (i_cfg.en) begin
            case (i_cfg.idx)
                sts_pkg::CFG_SPS:   n_sps   = sps_cfg;
                sts_pkg::CFG_SWING: n_swing = i_cfg.data[sts_pkg::SWING_W-1:0];
                sts_pkg::CFG_STEPS: begin
                    n_steps = steps_cfg;
                    if ({1'b0, r_pos_step} >= steps_cfg) begin
                        n_pos_step = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res_push = push_done || (emit_go && res_room && r_hold_vld);
    always_comb begin
        o_res      = r_hold;
        o_res.last = push_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sps        <= sts_pkg::SPS_RESET;
            r_swing      <= '0;
            r_steps      <= (32'(sts_pkg::STEPS_RESET) > STEPS_MAX)
                            ? sts_pkg::STEPS_W'(STEPS_MAX) : sts_pkg::STEPS_RESET;
            r_running    <= 1'b0;
            r_pos_step   <= '0;
            r_acc        <= '0;
            r_fire_first <= 1'b0;
            r_pcount     <= '0;
            r_di         <= '0;
            r_dw         <= '0;
            r_hold_vld   <= 1'b0;
            r_res_n      <= '0;
            r_off_vld    <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pattern[c] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_sps        <= n_sps;
            r_swing      <= n_swing;
            r_steps      <= n_steps;
            r_running    <= n_running;
            r_pos_step   <= n_pos_step;
            r_acc        <= n_acc;
            r_fire_first <= n_fire_first;
            r_pcount     <= n_pcount;
            r_di         <= n_di;
            r_dw         <= n_dw;
            r_hold_vld   <= n_hold_vld;
            r_res_n      <= n_res_n;
            if (off_we) begin
                r_off_vld[i_item.step[ST_W-1:0]] <= 1'b1;
            end
            if (pat_we) begin
                r_pattern[CH_W'(i_item.chan)][i_item.step[ST_W-1:0]] <= i_item.act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_tf   <= n_tf;
        r_fpos <= n_fpos;
        r_prod <= n_prod;
        r_so   <= n_so;
        r_ch   <= n_ch;
        r_hold <= n_hold;
    end

    // Step offset memory, one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (off_we) begin
            off_mem[i_item.step[ST_W-1:0]] <= toff_clamped;
        end
        r_off_q     <= off_mem[off_raddr];
        r_off_vld_q <= r_off_vld[off_raddr];
    end

    // Pending trigger memory, compacted in place while draining.
    always_ff @(posedge i_clk) begin
        if (pq_we) begin
            pq_mem[pq_waddr] <= pq_wdata;
        end
        r_pq_q <= pq_mem[pq_raddr];
    end

`ifndef NO_ASSERTIONS
    a_pcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= QC_W'(QUEUE_DEPTH))
        else $error("pending trigger count exceeds queue depth");
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_n <= sts_pkg::RES_CNT_W'(sts_pkg::MAX_RESULTS))
        else $error("result count exceeds the per-item limit");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_hold_vld) |=> (r_state == S_IDLE && r_res_n == '0))
        else $error("item finished without clearing its result count");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_pos_step} < r_steps))
        else $error("step position outside the pattern loop");
`endif

endmodule

>>> src/swing_step_sequencer.sv
// Top level of the swing step sequencer: input queue, sequencer core, result queue.
// Depends on sts_pkg, sts_front, sts_core and sts_out_fifo.
//
//   Channel  Direction  Handshake               Payload
//   input    in         push / full             op, num_samples, step_index,
//                                               channel_index, step_active, timing_offset
//   result   out        empty / pop             trigger_channel, trigger_step,
//                                               sample_offset, last
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Start, stop, pattern and offset items are handled in the idle state of the core. A
// block item first drains the queued triggers, then for every step it fires runs the
// two-pass multiplier of the step engine for swing and offset and scans the pattern
// one channel per cycle, unless a full result queue stalls the scan.
// Reset is synchronous and active low; no clearing pass is needed.
// A full result queue stalls the core, which then stops taking items; the input
// queue still holds up to two items.
module swing_step_sequencer #(
    parameter int CHANNELS    = sts_pkg::CHANNELS_DEF,
    parameter int STEPS_MAX   = sts_pkg::STEPS_MAX_DEF,
    parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sts_pkg::OP_W-1:0]          i_op,
    input  logic [sts_pkg::NS_W-1:0]          i_num_samples,
    input  logic [sts_pkg::STEP_W-1:0]        i_step_index,
    input  logic [sts_pkg::CHAN_W-1:0]        i_channel_index,
    input  logic                              i_step_active,
    input  logic signed [sts_pkg::TOFF_W-1:0] i_timing_offset,
    output logic                              empty,
    input  logic                              pop,
    output logic [sts_pkg::CHAN_W-1:0]        o_trigger_channel,
    output logic [sts_pkg::STEP_W-1:0]        o_trigger_step,
    output logic [sts_pkg::SOFF_W-1:0]        o_sample_offset,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sts_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [sts_pkg::SPS_W-1:0]         i_cfg_data
);

    sts_pkg::t_item   item;
    logic             item_valid, item_take;
    sts_pkg::t_res    core_res, head;
    logic             res_push, res_full;
    sts_pkg::t_cfg_wr cfg;

    // Configuration is always taken; every transfer lands in the core at once.
    assign o_cfg_ready = 1'b1;
    assign cfg.en      = i_cfg_valid;
    assign cfg.idx     = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    sts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_num_samples   (i_num_samples),
        .i_step_index    (i_step_index),
        .i_channel_index (i_channel_index),
        .i_step_active   (i_step_active),
        .i_timing_offset (i_timing_offset),
        .o_item          (item),
        .o_valid         (item_valid),
        .i_take          (item_take)
    );

    sts_core #(
        .CHANNELS    (CHANNELS),
        .STEPS_MAX   (STEPS_MAX),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_take  (item_take),
        .o_res        (core_res),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    sts_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (core_res),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (head)
    );

    assign o_trigger_channel = head.chan;
    assign o_trigger_step    = head.step;
    assign o_sample_offset   = head.offset;
    assign o_last            = head.last;

endmodule

>>> tb/sv/tb_swing_step_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for swing_step_sequencer: directed table, then random phases.
// Depends on sts_pkg and the swing_step_sequencer RTL; needs no other file.
module tb_swing_step_sequencer;

    // Operation codes that the block does not know. They must be ignored.
    localparam logic [sts_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [sts_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [sts_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;
    // Register index past the end of the list; writes to it change nothing.
    localparam logic [sts_pkg::CFGI_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint ONE_SAMPLE = 64'd65536;

    // How a row of the directed table is checked.
    typedef enum int { CHK_PRED, CHK_NONE, CHK_ONE } t_chk;

    typedef struct {
        logic [sts_pkg::OP_W-1:0]          op;
        logic [sts_pkg::NS_W-1:0]          ns;
        logic [sts_pkg::STEP_W-1:0]        step;
        logic [sts_pkg::CHAN_W-1:0]        chan;
        logic                              act;
        logic signed [sts_pkg::TOFF_W-1:0] toff;
        t_chk                              chk;
        logic [sts_pkg::CHAN_W-1:0]        e_chan;
        logic [sts_pkg::STEP_W-1:0]        e_step;
        logic [sts_pkg::SOFF_W-1:0]        e_off;
    } t_row;

    typedef struct {
        int     chan;
        int     step;
        longint wait_n;
    } t_held;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              push = 1'b0;
    logic                              full;
    logic [sts_pkg::OP_W-1:0]          i_op = '0;
    logic [sts_pkg::NS_W-1:0]          i_num_samples = '0;
    logic [sts_pkg::STEP_W-1:0]        i_step_index = '0;
    logic [sts_pkg::CHAN_W-1:0]        i_channel_index = '0;
    logic                              i_step_active = 1'b0;
    logic signed [sts_pkg::TOFF_W-1:0] i_timing_offset = '0;
    logic                              empty;
    logic                              pop = 1'b0;
    logic [sts_pkg::CHAN_W-1:0]        o_trigger_channel;
    logic [sts_pkg::STEP_W-1:0]        o_trigger_step;
    logic [sts_pkg::SOFF_W-1:0]        o_sample_offset;
    logic                              o_last;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [sts_pkg::CFGI_W-1:0]        i_cfg_index = '0;
    logic [sts_pkg::SPS_W-1:0]         i_cfg_data = '0;

    swing_step_sequencer dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Generous wall for the whole run; the slowest legal run is far shorter.
    initial begin
        #100ms;
        $display("tb_swing_step_sequencer failed");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer's registers.
    // ---------------------------------------------------------------------
    longint        step_len_q16;   // samples_per_step as written
    int            swing_q16;
    int            loop_len;
    bit            seq_running;
    int            cur_step;
    longint        acc_q16;
    bit            arm_first;
    logic [63:0]   pattern [sts_pkg::CHANNELS_DEF];
    int            step_offs [sts_pkg::STEPS_MAX_DEF];
    t_held         held [$];       // triggers waiting for a later block
    sts_pkg::t_res batch [$];      // triggers of the item being predicted
    sts_pkg::t_res trig_due [$];   // triggers the block still owes us
    longint        work_est;       // rough core cycles spent since the last idle point

    int n_errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;

    task automatic report(input string what);
        n_errors++;
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    function automatic longint eff_len();
        return step_len_q16 < ONE_SAMPLE ? ONE_SAMPLE : step_len_q16;
    endfunction

    // Round a fixed-point value to whole units, half away from zero.
    function automatic longint round_away(input longint v, input int frac);
        longint half;
        half = 64'sd1 <<< (frac - 1);
        if (v >= 0) return (v + half) >>> frac;
        return -((-v + half) >>> frac);
    endfunction

    function automatic void note_trig(input int ch, input int st, input longint off);
        sts_pkg::t_res r;
        if (batch.size() >= sts_pkg::MAX_RESULTS) return;
        r.chan = ch[sts_pkg::CHAN_W-1:0];
        r.step = st[sts_pkg::STEP_W-1:0];
        r.offset = off[sts_pkg::SOFF_W-1:0];
        r.last = 1'b0;
        batch.push_back(r);
    endfunction

    // Sound the current step at base, shifted by swing and by the step's own offset.
    function automatic void sound_step(input longint base, input int ns);
        longint len, p;
        int st, so;
        t_held h;
        len = eff_len();
        st = cur_step % sts_pkg::STEPS_MAX_DEF;
        so = step_offs[st];
        p = base;
        if (swing_q16 > int'(sts_pkg::SWING_MIN) && st[0])
            p += round_away(longint'(swing_q16) * len, 32);
        if (so > int'(sts_pkg::TOFF_MIN_MAG) || so < -int'(sts_pkg::TOFF_MIN_MAG))
            p += round_away(longint'(so) * len, 31);
        if (p < 0) p = 0;
        work_est += 9 + sts_pkg::CHANNELS_DEF;
        for (int ch = 0; ch < sts_pkg::CHANNELS_DEF; ch++) begin
            if (!pattern[ch][st]) continue;
            if (p < ns) begin
                note_trig(ch, st, p);
            end else if (held.size() < sts_pkg::QUEUE_DEPTH_DEF) begin
                h.chan = ch;
                h.step = st;
                h.wait_n = p - ns;
                held.push_back(h);
            end
        end
    endfunction

    function automatic void run_block(input int ns);
        longint len, to_fire, b;
        t_held keep [$];
        if (!seq_running || ns == 0) return;
        len = eff_len();
        // Queued triggers that fall inside this block go out first.
        work_est += 2 * held.size();
        foreach (held[i]) begin
            if (held[i].wait_n < ns) begin
                note_trig(held[i].chan, held[i].step, held[i].wait_n);
            end else begin
                keep.push_back(held[i]);
                keep[$].wait_n -= ns;
            end
        end
        held = keep;
        if (arm_first) begin
            arm_first = 1'b0;
            sound_step(0, ns);
        end
        to_fire = len - acc_q16;
        acc_q16 += longint'(ns) << 16;
        while (acc_q16 >= len) begin
            acc_q16 -= len;
            b = round_away(to_fire, 16);
            if (b < 0) b = 0;
            if (b > ns - 1) b = ns - 1;
            cur_step = (cur_step + 1) % loop_len;
            sound_step(b, ns);
            to_fire += len;
        end
    endfunction

    // Advance the predictor by one accepted item; its triggers land in batch.
    function automatic void predict_item(input logic [sts_pkg::OP_W-1:0] op, input int ns,
                                         input int si, input int ci, input bit act,
                                         input int toff);
        batch.delete();
        work_est += 4;
        case (op)
            sts_pkg::OP_PROCESS: run_block(ns);
            sts_pkg::OP_START: begin
                cur_step = si > loop_len - 1 ? loop_len - 1 : si;
                acc_q16 = 0;
                seq_running = 1'b1;
                arm_first = 1'b1;
                held.delete();
            end
            sts_pkg::OP_STOP: begin
                seq_running = 1'b0;
                held.delete();
            end
            sts_pkg::OP_PATTERN: begin
                if (ci < sts_pkg::CHANNELS_DEF && si < loop_len) pattern[ci][si] = act;
            end
            sts_pkg::OP_OFFSET: begin
                if (toff > int'(sts_pkg::TOFF_CLAMP)) toff = int'(sts_pkg::TOFF_CLAMP);
                if (toff < -int'(sts_pkg::TOFF_CLAMP)) toff = -int'(sts_pkg::TOFF_CLAMP);
                step_offs[si] = toff;
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[$].last = 1'b1;
    endfunction

    function automatic void predict_cfg(input logic [sts_pkg::CFGI_W-1:0] idx,
                                        input logic [sts_pkg::SPS_W-1:0] data);
        int c;
        case (idx)
            sts_pkg::CFG_SPS:   step_len_q16 = longint'(data);
            sts_pkg::CFG_SWING: swing_q16 = int'(data[sts_pkg::SWING_W-1:0]);
            sts_pkg::CFG_STEPS: begin
                c = int'(data[sts_pkg::STEPS_W-1:0]);
                if (c < 1) c = 1;
                if (c > sts_pkg::STEPS_MAX_DEF) c = sts_pkg::STEPS_MAX_DEF;
                loop_len = c;
                if (cur_step >= loop_len) cur_step = 0;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Input side. An item is offered with push high and counts as a transfer
    // at the first edge where full is low. Right after the transfer, the
    // sender either offers the next item in the same time step or drops push
    // for a random gap, so push never gets two updates in one step.
    // ---------------------------------------------------------------------
    task automatic send_item(input logic [sts_pkg::OP_W-1:0] op,
                             input logic [sts_pkg::NS_W-1:0] ns,
                             input logic [sts_pkg::STEP_W-1:0] si,
                             input logic [sts_pkg::CHAN_W-1:0] ci,
                             input logic act,
                             input logic signed [sts_pkg::TOFF_W-1:0] toff,
                             input t_chk chk, input sts_pkg::t_res typed);
        push <= 1'b1;
        i_op <= op;
        i_num_samples <= ns;
        i_step_index <= si;
        i_channel_index <= ci;
        i_step_active <= act;
        i_timing_offset <= toff;
        do @(posedge i_clk); while (full);
        n_items++;
        predict_item(op, int'(ns), int'(si), int'(ci), act, int'(toff));
        // Rows with a hand-written answer use it in place of the predictor's.
        if (chk == CHK_PRED) begin
            foreach (batch[i]) trig_due.push_back(batch[i]);
        end else if (chk == CHK_ONE) begin
            trig_due.push_back(typed);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop offering, let every owed trigger arrive, then give the core time
    // to finish any block that produced nothing visible.
    task automatic settle();
        push <= 1'b0;
        while (trig_due.size() > 0) @(posedge i_clk);
        repeat (int'(work_est) * 2 + 40) @(posedge i_clk);
        work_est = 0;
    endtask

    // Leaves i_cfg_valid high; the caller lowers it after its last write.
    task automatic cfg_write(input logic [sts_pkg::CFGI_W-1:0] idx,
                             input logic [sts_pkg::SPS_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        predict_cfg(idx, data);
    endtask

    task automatic set_timing(input longint len, input int swing, input int steps);
        settle();
        cfg_write(sts_pkg::CFG_SPS, len[sts_pkg::SPS_W-1:0]);
        cfg_write(sts_pkg::CFG_SWING, swing[sts_pkg::SWING_W-1:0]);
        cfg_write(sts_pkg::CFG_STEPS, steps[sts_pkg::STEPS_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Result side. A result is a transfer at an edge with pop high and empty
    // low. The receiver idles at random and, on request, holds pop low for a
    // long stretch so the result queue fills and the block stalls its input.
    // ---------------------------------------------------------------------
    initial begin
        int            hold_left;
        int            hold_taken;
        sts_pkg::t_res want;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (trig_due.size() == 0) begin
                    report($sformatf("trigger ch %0d step %0d with none owed",
                                     o_trigger_channel, o_trigger_step));
                end else begin
                    want = trig_due.pop_front();
                    n_checked++;
                    if (o_trigger_channel !== want.chan)
                        report($sformatf("channel %0d, want %0d", o_trigger_channel, want.chan));
                    if (o_trigger_step !== want.step)
                        report($sformatf("step %0d, want %0d", o_trigger_step, want.step));
                    if (o_sample_offset !== want.offset)
                        report($sformatf("offset %0d, want %0d", o_sample_offset, want.offset));
                    if (o_last !== want.last)
                        report($sformatf("last %0b, want %0b", o_last, want.last));
                end
            end
            if (hold_req != hold_taken) begin
                hold_taken = hold_req;
                hold_left = 800;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Directed rows, written for a 100-sample step, no swing and a 16-step loop.
    t_row dir_rows [] = '{
        // Stopped: a block does nothing.
        '{sts_pkg::OP_PROCESS, 13'd64,   6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        // Unknown operations are ignored, whatever the fields hold.
        '{OP_RSVD_5,           13'd8191, 6'd63, 3'd7, 1'b1, -16'sd1,    CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{OP_RSVD_6,           13'd4096, 6'd0,  3'd0, 1'b0, 16'sd32767, CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{OP_RSVD_7,           13'd1,    6'd42, 3'd5, 1'b1, 16'sh8000,  CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PATTERN, 13'd0,    6'd0,  3'd0, 1'b1, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PATTERN, 13'd8191, 6'd15, 3'd7, 1'b1, -16'sd1,    CHK_NONE,
          3'd0, 6'd0,  12'd0},
        // Step past the loop length: the pattern write is dropped.
        '{sts_pkg::OP_PATTERN, 13'd0,    6'd16, 3'd3, 1'b1, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        // Offsets: both clamps, and magnitudes on either side of the dead zone.
        '{sts_pkg::OP_OFFSET,  13'd0,    6'd63, 3'd0, 1'b0, 16'sd32767, CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_OFFSET,  13'd0,    6'd1,  3'd0, 1'b0, 16'sh8000,  CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_OFFSET,  13'd0,    6'd2,  3'd0, 1'b0, 16'sd32,    CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_OFFSET,  13'd0,    6'd3,  3'd0, 1'b0, -16'sd33,   CHK_NONE,
          3'd0, 6'd0,  12'd0},
        // Start step past the loop is clamped to the last step.
        '{sts_pkg::OP_START,   13'd0,    6'd63, 3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PROCESS, 13'd1,    6'd0,  3'd0, 1'b0, 16'sd0,     CHK_ONE,
          3'd7, 6'd15, 12'd0},
        // Empty block.
        '{sts_pkg::OP_PROCESS, 13'd0,    6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_STOP,    13'd0,    6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PATTERN, 13'd0,    6'd1,  3'd2, 1'b1, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_START,   13'd0,    6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PROCESS, 13'd4096, 6'd0,  3'd0, 1'b0, 16'sd0,     CHK_PRED,
          3'd0, 6'd0,  12'd0},
        // Wide block: step offsets past 12 bits wrap.
        '{sts_pkg::OP_PROCESS, 13'd8191, 6'd0,  3'd0, 1'b0, 16'sd0,     CHK_PRED,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PATTERN, 13'd0,    6'd15, 3'd7, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PROCESS, 13'd37,   6'd0,  3'd0, 1'b0, 16'sd0,     CHK_PRED,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_STOP,    13'd0,    6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_PROCESS, 13'd10,   6'd0,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0},
        '{sts_pkg::OP_START,   13'd0,    6'd5,  3'd0, 1'b0, 16'sd0,     CHK_NONE,
          3'd0, 6'd0,  12'd0}
    };

    // One random item. Most are blocks of modest length; the other fields
    // stay fully random so that every input bit toggles.
    task automatic send_random();
        logic [sts_pkg::OP_W-1:0] op;
        logic [sts_pkg::NS_W-1:0] ns;
        int pick;
        sts_pkg::t_res none;
        none = '0;
        pick = $urandom_range(99);
        ns = sts_pkg::NS_W'($urandom);
        if (pick < 58) begin
            op = sts_pkg::OP_PROCESS;
            case ($urandom_range(9))
                0:       ns = '0;
                1:       ns = eff_len() >= 16 * ONE_SAMPLE ? 13'd4096 : 13'd400;
                2, 3, 4: ns = sts_pkg::NS_W'($urandom_range(41, 400));
                default: ns = sts_pkg::NS_W'($urandom_range(1, 40));
            endcase
        end else if (pick < 76) op = sts_pkg::OP_PATTERN;
        else if (pick < 86) op = sts_pkg::OP_OFFSET;
        else if (pick < 93) op = sts_pkg::OP_START;
        else if (pick < 97) op = sts_pkg::OP_STOP;
        else op = 3'($urandom_range(int'(OP_RSVD_5), int'(OP_RSVD_7)));
        send_item(op, ns, sts_pkg::STEP_W'($urandom), sts_pkg::CHAN_W'($urandom),
                  ($urandom_range(9) < 7), sts_pkg::TOFF_W'($urandom),
                  CHK_PRED, none);
    endtask

    initial begin
        longint lens [6];
        int swings [6];
        int loops [6];
        sts_pkg::t_res typed;

        seq_running = 1'b0;
        cur_step = 0;
        acc_q16 = 0;
        arm_first = 1'b0;
        step_len_q16 = longint'(sts_pkg::SPS_RESET);
        swing_q16 = 0;
        loop_len = int'(sts_pkg::STEPS_RESET);
        work_est = 0;
        foreach (pattern[i]) pattern[i] = '0;
        foreach (step_offs[i]) step_offs[i] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register index past the list must change nothing.
        cfg_write(CFG_UNUSED, '1);
        i_cfg_valid <= 1'b0;
        set_timing(100 * ONE_SAMPLE, 0, 16);
        send_idle_pct = 9;
        recv_idle_pct = 45;
        foreach (dir_rows[i]) begin
            typed.chan = dir_rows[i].e_chan;
            typed.step = dir_rows[i].e_step;
            typed.offset = dir_rows[i].e_off;
            typed.last = 1'b1;
            send_item(dir_rows[i].op, dir_rows[i].ns, dir_rows[i].step, dir_rows[i].chan,
                      dir_rows[i].act, dir_rows[i].toff, dir_rows[i].chk, typed);
        end

        // Random phases. The sequencer keeps running across a phase change,
        // so a shorter step length also exercises steps that are already late.
        lens   = '{100 * ONE_SAMPLE + 12345, 37 * ONE_SAMPLE + 777, ONE_SAMPLE,
                   (64'd1 << sts_pkg::SPS_W) - 1, 64'd0, 5 * ONE_SAMPLE + 32768};
        swings = '{32768, 20000, 66, 65, 65535, 0};
        loops  = '{16, 7, 64, 1, 0, 127};
        for (int ph = 0; ph < 6; ph++) begin
            set_timing(lens[ph], swings[ph], loops[ph]);
            for (int k = 0; k < 42; k++) begin
                if (n_items < 110) begin
                    send_idle_pct = 9;
                    recv_idle_pct = 45;
                end else if (n_items < 200) begin
                    send_idle_pct = 45;
                    recv_idle_pct = 9;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // Starve the result side once while blocks keep coming.
                if (ph == 1 && k == 5) hold_req++;
                send_random();
            end
        end

        settle();
        repeat (200) @(posedge i_clk);
        if (trig_due.size() > 0) report("triggers still owed at the end");
        $display("Covered %0d items in a directed table and six timing settings.", n_items);
        $display("Checked %0d triggers against the predictor.", n_checked);
        if (n_errors == 0) begin
            $display("tb_swing_step_sequencer passed");
        end else begin
            $display("tb_swing_step_sequencer failed");
        end
        $finish;
    end

endmodule
